// ===== sv/h2s_pkg.sv =====
package h2s_pkg;

	// Channel and field widths.
	localparam int HalfW  = 16;
	localparam int ByteW  = 8;
	localparam int FixW   = 25;
	localparam int LevelN = 256;

	// Half pattern of 1.0; everything at or above it saturates.
	localparam logic [HalfW-1:0] HalfOne = 16'h3C00;

	// True for a NaN pattern of either sign.
	function automatic logic is_nan(input logic [HalfW-1:0] code);
		return (code[14:10] == 5'h1F) && (code[9:0] != 10'd0);
	endfunction

	// Half value in [0,1] as an integer scaled by 2^24 (exact, subnormals included).
	function automatic logic [FixW-1:0] half_to_fixed(input logic [HalfW-1:0] code);
		logic [4:0] e;
		logic [9:0] m;
		e = code[14:10];
		m = code[9:0];
		if (code >= HalfOne) begin
			return 25'h1000000;
		end
		if (e == 5'd0) begin
			return 25'(m);
		end
		return 25'({1'b1, m}) << (e - 5'd1);
	endfunction

	// Exact test whether the sRGB value of a half pattern reaches (k - 1/2) / 255.
	function automatic logic reaches(input logic [HalfW-1:0] code, input int k);
		logic [FixW-1:0] n;
		logic [63:0]     n64;
		logic [19:0]     a;
		logic [383:0]    lhs;
		logic [383:0]    rhs;
		n   = half_to_fixed(code);
		n64 = 64'(n);
		if (n64 * 64'd10000000 <= (64'd31308 << 24)) begin
			return (64'd658920 * n64) >= (64'(2 * k - 1) * 64'd100 * (64'd1 << 24));
		end
		a   = 20'(1000 * (2 * k - 1) + 28050);
		lhs = 384'd1;
		rhs = 384'd1;
		for (int i = 0; i < 5; i++) begin
			lhs = lhs * 384'(n);
			rhs = rhs << 24;
		end
		for (int i = 0; i < 12; i++) begin
			lhs = lhs * 384'd538050;
			rhs = rhs * 384'(a);
		end
		return lhs >= rhs;
	endfunction

	// Smallest half pattern whose encoded value rounds to level k or above.
	function automatic logic [HalfW-1:0] thr_of(input int k);
		logic [HalfW-1:0] lo;
		logic [HalfW-1:0] hi;
		logic [HalfW-1:0] mid;
		lo = 16'h0000;
		hi = HalfOne;
		for (int i = 0; i < 16; i++) begin
			if (lo < hi) begin
				mid = (lo + hi) >> 1;
				if (reaches(mid, k)) begin
					hi = mid;
				end else begin
					lo = mid + 16'd1;
				end
			end
		end
		return lo;
	endfunction

endpackage

// ===== sv/half_rgba_to_srgb8_bgra_core.sv =====
// Half-precision linear RGBA to sRGB 8-bit BGRA pixel converter.
//
// Input stream (s_*): one pixel per beat, four IEEE binary16 channels packed
// as red, green, blue, alpha from the low bits up. Output stream (m_*): one
// 32-bit BGRA pixel per beat, blue in the low byte and alpha in the high byte.
// Color channels follow the sRGB transfer curve, alpha is scaled linearly;
// negatives and NaN give 0, values at or above one give 255.
//
// Each color channel runs in its own lane through a bank of 255 constant
// threshold comparators; alpha runs in a multiply lane. A merge register packs
// the four bytes. Each lane registers its input in a first stage, the merge
// register follows it, and the block sustains one pixel per clock while the
// receiver keeps draining, as the comparator bank ahead of the first stage needs no iteration.
//
// Reset clears the stage valid flags only; there are no stored tables to fill.
// When the receiver stalls, the output beat holds and the first stage keeps
// accepting until it is also full, after which s_tready drops.
module half_rgba_to_srgb8_bgra_core import h2s_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // red_half, green_half, blue_half, alpha_half
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // blue_byte, green_byte, red_byte, alpha_byte
);

	logic             valid_s1;
	logic             merge_ready;
	logic             load;
	logic [ByteW-1:0] red_byte;
	logic [ByteW-1:0] green_byte;
	logic [ByteW-1:0] blue_byte;
	logic [ByteW-1:0] alpha_byte;

	// First stage advances when empty or when the merge register takes its beat.
	assign s_tready = !valid_s1 || merge_ready;
	assign load     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// One lane per channel.
	h2s_color_lane u_red (
		.clk       (clk),
		.load      (load),
		.code      (s_tdata[15:0]),
		.srgb_byte (red_byte)
	);

	h2s_color_lane u_green (
		.clk       (clk),
		.load      (load),
		.code      (s_tdata[31:16]),
		.srgb_byte (green_byte)
	);

	h2s_color_lane u_blue (
		.clk       (clk),
		.load      (load),
		.code      (s_tdata[47:32]),
		.srgb_byte (blue_byte)
	);

	h2s_alpha_lane u_alpha (
		.clk        (clk),
		.load       (load),
		.code       (s_tdata[63:48]),
		.alpha_byte (alpha_byte)
	);

	// Combine the lane results into the output beat.
	h2s_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (valid_s1),
		.in_ready   (merge_ready),
		.blue_byte  (blue_byte),
		.green_byte (green_byte),
		.red_byte   (red_byte),
		.alpha_byte (alpha_byte),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata)
	);

endmodule

// ===== sv/h2s_color_lane.sv =====
module h2s_color_lane import h2s_pkg::*; (
	input  logic             clk,
	input  logic             load,
	input  logic [HalfW-1:0] code,
	output logic [ByteW-1:0] srgb_byte
);

	logic [LevelN-1:1] therm;
	logic [LevelN-1:1] therm_s1;
	logic              ok_s1;
	logic [LevelN:1]   tx;
	logic [ByteW-1:0][LevelN/2-1:0] terms;

	// Compare the code against every level threshold; the result is a thermometer.
	genvar k;
	for (k = 1; k < LevelN; k++) begin : g_thr
		localparam logic [HalfW-1:0] Thr = thr_of(k);
		assign therm[k] = (code >= Thr);
	end

	// First stage: thermometer and the sign/NaN guard.
	always_ff @(posedge clk) begin
		if (load) begin
			therm_s1 <= therm;
			ok_s1    <= !code[HalfW-1] && !is_nan(code);
		end
	end

	// Thermometer to binary: bit b is set where the edge falls in an odd block of 2^b.
	assign tx = {1'b0, therm_s1};

	genvar b, m;
	for (b = 0; b < ByteW; b++) begin : g_bit
		for (m = 0; m < LevelN / 2; m++) begin : g_term
			localparam int Idx = (2 * m + 1) << b;
			if (Idx < LevelN) begin : g_on
				assign terms[b][m] = tx[Idx] & ~tx[Idx + (1 << b)];
			end else begin : g_off
				assign terms[b][m] = 1'b0;
			end
		end
		assign srgb_byte[b] = ok_s1 & (|terms[b]);
	end

endmodule

// ===== sv/h2s_alpha_lane.sv =====
module h2s_alpha_lane import h2s_pkg::*; (
	input  logic             clk,
	input  logic             load,
	input  logic [HalfW-1:0] code,
	output logic [ByteW-1:0] alpha_byte
);

	logic [FixW-1:0] fix_s1;
	logic            ok_s1;
	logic            sat_s1;
	logic [34:0]     scaled;

	// First stage: fixed-point value and the special-case flags.
	always_ff @(posedge clk) begin
		if (load) begin
			fix_s1 <= half_to_fixed(code);
			ok_s1  <= !code[HalfW-1] && !is_nan(code);
			sat_s1 <= (code >= HalfOne);
		end
	end

	// Scale by 255 and round half up: (510 n + 2^24) >> 25.
	assign scaled = 35'(fix_s1) * 35'd510 + (35'd1 << 24);

	always_comb begin
		if (!ok_s1) begin
			alpha_byte = '0;
		end else if (sat_s1) begin
			alpha_byte = '1;
		end else begin
			alpha_byte = scaled[32:25];
		end
	end

endmodule

// ===== sv/h2s_merge.sv =====
module h2s_merge import h2s_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ByteW-1:0] blue_byte,
	input  logic [ByteW-1:0] green_byte,
	input  logic [ByteW-1:0] red_byte,
	input  logic [ByteW-1:0] alpha_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      out_data
);

	logic             valid_s2;
	logic [4*ByteW-1:0] data_s2;

	// The output register takes a new beat when empty or being drained.
	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	// Pack the lane results in B, G, R, A byte order.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= {alpha_byte, red_byte, green_byte, blue_byte};
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ===== sv/h2s_checker.sv =====
module h2s_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// A stalled output beat stays valid and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	// A draining receiver never blocks the input side.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while the output drains");

	// With the receiver ready while the pixel sits in the first stage, an accepted pixel reaches the output beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
		else $error("pixel lost in the pipeline");

	// A negative red channel encodes to zero in byte 2.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tdata[15]) ##1 m_tready |=> m_tdata[23:16] == 8'd0)
		else $error("negative red did not encode to zero");

	// Alpha of exactly one encodes to 255 in byte 3.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tdata[63:48] == 16'h3C00) ##1 m_tready
		|=> m_tdata[31:24] == 8'hFF)
		else $error("alpha of one did not encode to 255");

endmodule

bind half_rgba_to_srgb8_bgra_core h2s_checker u_h2s_checker (.*);
